>>> src/md5s_pkg.sv
// ============================================================================
// md5s_pkg: shared types and constants for the streaming MD5 hasher
// Holds the initial chaining values, the round table and the block command.
// ============================================================================
package md5s_pkg;

   localparam logic [31:0] INIT_A = 32'h67452301;
   localparam logic [31:0] INIT_B = 32'hEFCDAB89;
   localparam logic [31:0] INIT_C = 32'h98BADCFE;
   localparam logic [31:0] INIT_D = 32'h10325476;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   // one block handed from the front to the core
   typedef struct packed {
      logic [511:0] block;   // byte i at bits [8*i+7:8*i]
      logic         final_blk; // emit digest and reload after this block
   } blk_cmd_type;

   function automatic logic [31:0] round_add(input logic [5:0] i);
      logic [31:0] t [64];
      t = '{
         32'hD76AA478, 32'hE8C7B756, 32'h242070DB, 32'hC1BDCEEE,
         32'hF57C0FAF, 32'h4787C62A, 32'hA8304613, 32'hFD469501,
         32'h698098D8, 32'h8B44F7AF, 32'hFFFF5BB1, 32'h895CD7BE,
         32'h6B901122, 32'hFD987193, 32'hA679438E, 32'h49B40821,
         32'hF61E2562, 32'hC040B340, 32'h265E5A51, 32'hE9B6C7AA,
         32'hD62F105D, 32'h02441453, 32'hD8A1E681, 32'hE7D3FBC8,
         32'h21E1CDE6, 32'hC33707D6, 32'hF4D50D87, 32'h455A14ED,
         32'hA9E3E905, 32'hFCEFA3F8, 32'h676F02D9, 32'h8D2A4C8A,
         32'hFFFA3942, 32'h8771F681, 32'h6D9D6122, 32'hFDE5380C,
         32'hA4BEEA44, 32'h4BDECFA9, 32'hF6BB4B60, 32'hBEBFBC70,
         32'h289B7EC6, 32'hEAA127FA, 32'hD4EF3085, 32'h04881D05,
         32'hD9D4D039, 32'hE6DB99E5, 32'h1FA27CF8, 32'hC4AC5665,
         32'hF4292244, 32'h432AFF97, 32'hAB9423A7, 32'hFC93A039,
         32'h655B59C3, 32'h8F0CCC92, 32'hFFEFF47D, 32'h85845DD1,
         32'h6FA87E4F, 32'hFE2CE6E0, 32'hA3014314, 32'h4E0811A1,
         32'hF7537E82, 32'hBD3AF235, 32'h2AD7D2BB, 32'hEB86D391};
      return t[i];
   endfunction

   function automatic logic [4:0] rot_amt(input logic [5:0] i);
      logic [4:0] t [16];
      t = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
            5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
      return t[{i[5:4], i[1:0]}];
   endfunction

   // message word index used by round i
   function automatic logic [3:0] word_sel(input logic [5:0] i);
      logic [3:0] g;
      unique case (i[5:4])
         2'd0: g = i[3:0];
         2'd1: g = 4'(5 * i[3:0] + 1);
         2'd2: g = 4'(3 * i[3:0] + 5);
         default: g = 4'(7 * i[3:0]);
      endcase
      return g;
   endfunction

endpackage

>>> src/md5s_front.sv
// ============================================================================
// md5s_front: byte collector and padder
// Gathers bytes into a block, counts the length, pads at end of message and
// pushes full blocks into the command queue.
// ============================================================================
module md5s_front
   import md5s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_is_last,
   output logic        cmd_valid,
   input  logic        cmd_ready,
   output blk_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_COLLECT = 3'b001,
      ST_PAD1    = 3'b010,
      ST_PAD2    = 3'b100
   } state_type;

   state_type    state_ff, state_in;
   logic [511:0] buf_ff, buf_in;
   logic [60:0]  count_ff, count_in;
   logic         cmd_valid_ff, cmd_valid_in;
   blk_cmd_type  cmd_ff, cmd_in;
   logic [5:0]   pos;
   logic [63:0]  bits;
   logic         take;
   logic         slot_free;

   assign pos       = count_ff[5:0];
   assign bits      = {count_ff, 3'b000};
   assign slot_free = !cmd_valid_ff || cmd_ready;
   assign req_full  = (state_ff != ST_COLLECT) || !slot_free;
   assign take      = req_push && !req_full;
   assign cmd_valid = cmd_valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      logic [511:0] b;
      state_in     = state_ff;
      buf_in       = buf_ff;
      count_in     = count_ff;
      cmd_valid_in = cmd_valid_ff && !cmd_ready;
      cmd_in       = cmd_ff;
      b            = buf_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (take) begin
               if (req_byte_present) begin
                  b[8*pos +: 8] = req_data_byte;
                  buf_in   = b;
                  count_in = count_ff + 61'd1;
                  if (pos == 6'd63) begin
                     cmd_valid_in    = 1'b1;
                     cmd_in.block    = b;
                     cmd_in.final_blk = 1'b0;
                  end
               end
               if (req_is_last) begin
                  buf_in = b;
                  state_in = ST_PAD1;
               end
            end
         end
         ST_PAD1: begin
            // pad the partial block; length fits only below byte 56
            if (slot_free) begin
               for (int k = 0; k < 64; k++) begin
                  if (k == pos) b[8*k +: 8] = 8'h80;
                  else if (k > pos) b[8*k +: 8] = 8'h00;
               end
               cmd_valid_in = 1'b1;
               if (pos < 6'd56) begin
                  b[511:448]      = bits;
                  cmd_in.final_blk = 1'b1;
                  state_in        = ST_COLLECT;
                  count_in        = '0;
               end else begin
                  cmd_in.final_blk = 1'b0;
                  state_in        = ST_PAD2;
               end
               cmd_in.block = b;
            end
         end
         ST_PAD2: begin
            if (slot_free) begin
               cmd_valid_in     = 1'b1;
               cmd_in.block     = {bits, 448'd0};
               cmd_in.final_blk = 1'b1;
               state_in         = ST_COLLECT;
               count_in         = '0;
            end
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_COLLECT;
         count_ff     <= '0;
         cmd_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cmd_valid_ff <= cmd_valid_in;
      end
      buf_ff <= buf_in;
      cmd_ff <= cmd_in;
   end

endmodule

>>> src/md5s_queue.sv
// ============================================================================
// md5s_queue: block command queue
// Short FIFO that decouples the padder from the compression core.
// ============================================================================
module md5s_queue
   import md5s_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  blk_cmd_type in_cmd,
   output logic        out_valid,
   input  logic        out_ready,
   output blk_cmd_type out_cmd
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   blk_cmd_type      mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             wr_en, rd_en;

   assign in_ready  = cnt_ff != (AW+1)'(DEPTH);
   assign out_valid = cnt_ff != '0;
   assign wr_en     = in_valid && in_ready;
   assign rd_en     = out_valid && out_ready;
   assign out_cmd   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_en ? ((wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = rd_en ? ((rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(wr_en) - (AW+1)'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (wr_en) mem_ff[wr_ff] <= in_cmd;
   end

endmodule

>>> src/md5s_core.sv
// ============================================================================
// md5s_core: MD5 compression core
// Runs one round per cycle over a queued block, folds the result into the
// chaining words and hands out the digest words after a final block.
// ============================================================================
module md5s_core
   import md5s_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  blk_cmd_type cmd,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_ROUND = 4'b0010,
      ST_FOLD  = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   state_type    state_ff, state_in;
   logic [31:0]  h_ff [4];
   logic [31:0]  h_in [4];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   logic [5:0]   rnd_ff, rnd_in;
   logic         fin_ff, fin_in;
   logic [1:0]   idx_ff, idx_in;
   logic [31:0]  f, w, sum, rot;
   logic [4:0]   s;
   logic [3:0]   g;

   assign cmd_ready       = state_ff == ST_IDLE;
   assign rsp_empty       = state_ff != ST_EMIT;
   assign rsp_digest_word = h_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_last_word   = idx_ff == 2'd3;

   always_comb begin
      unique case (rnd_ff[5:4])
         2'd0: f = d_ff ^ (b_ff & (c_ff ^ d_ff));
         2'd1: f = c_ff ^ (d_ff & (b_ff ^ c_ff));
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      g   = word_sel(rnd_ff);
      w   = cmd.block[32*g +: 32];
      s   = rot_amt(rnd_ff);
      sum = a_ff + f + round_add(rnd_ff) + w;
      rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
   end

   always_comb begin
      state_in = state_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      rnd_in = rnd_ff;
      fin_in = fin_ff;
      idx_in = idx_ff;
      h_in   = h_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               a_in = h_ff[0]; b_in = h_ff[1]; c_in = h_ff[2]; d_in = h_ff[3];
               rnd_in   = '0;
               fin_in   = cmd.final_blk;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            // block stays at the queue head through the last round
            a_in = d_ff; d_in = c_ff; c_in = b_ff;
            b_in = b_ff + rot;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            h_in[0] = h_ff[0] + a_ff;
            h_in[1] = h_ff[1] + b_ff;
            h_in[2] = h_ff[2] + c_ff;
            h_in[3] = h_ff[3] + d_ff;
            idx_in  = '0;
            state_in = fin_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_pop) begin
               idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) begin
                  h_in[0] = INIT_A; h_in[1] = INIT_B;
                  h_in[2] = INIT_C; h_in[3] = INIT_D;
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         h_ff[0]  <= INIT_A;
         h_ff[1]  <= INIT_B;
         h_ff[2]  <= INIT_C;
         h_ff[3]  <= INIT_D;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         h_ff     <= h_in;
         idx_ff   <= idx_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
      d_ff   <= d_in;
      rnd_ff <= rnd_in;
      fin_ff <= fin_in;
   end

endmodule

>>> src/md5_stream_hash.sv
// ============================================================================
// md5_stream_hash: streaming MD5 message hasher
// Byte-wide message input, four-word digest output per message.
// ============================================================================
// Usage:
//  Input: drive req_data_byte / req_byte_present / req_is_last with req_push;
//  a transfer happens on a clock edge with req_push high and req_full low.
//  Set req_is_last on the final byte (or on an item with no byte to close
//  an empty or already-fed message).
//  Output: while rsp_empty is low the oldest digest word sits on
//  rsp_digest_word / rsp_word_index / rsp_last_word; rsp_pop takes it.
//  Four words per message, A first, rsp_last_word on D.
// Timing:
//  The front takes one byte per cycle while req_full is low; a full block goes
//  into the block queue (two entries by default). For each block the core
//  loads the chaining words, runs the 64 rounds, one round per cycle, and
//  folds the result. Padding adds one or two blocks at end of message.
// Reset: clears counts and queue, reloads the initial chaining words.
// Stall: while the receiver holds off pop the core waits in its output
//  state; the queue then fills and req_full rises.
// ============================================================================
module md5_stream_hash
   import md5s_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_present,
   input  logic        req_is_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [1:0]  rsp_word_index,
   output logic        rsp_last_word
);

   logic        f_valid, f_ready, q_valid, q_ready, core_idle;
   blk_cmd_type f_cmd, q_cmd;

   md5s_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data_byte,
      .req_byte_present, .req_is_last,
      .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
   );

   // advance the queue head only when the core has run its last round
   md5s_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   md5s_core u_core (
      .clock, .reset,
      .cmd_valid(q_valid), .cmd_ready(core_idle), .cmd(q_cmd),
      .rsp_empty, .rsp_pop, .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );

   // the core reads the head block through all 64 rounds: mark the start,
   // count the rounds and release the head at the edge that ends round 63
   logic       busy_ff, busy_in;
   logic [6:0] cnt_ff, cnt_in;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      q_ready = 1'b0;
      if (!busy_ff) begin
         if (q_valid && core_idle) begin
            busy_in = 1'b1;
            cnt_in  = '0;
         end
      end else begin
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            q_ready = 1'b1;
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule
